[hw/rtl/lobm_pkg.sv]
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

  localparam int BOOK_DEPTH = 1024;
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
  localparam int FIELD_W    = 30;
  localparam logic [FIELD_W-1:0] MODULUS = 30'd1000000007;

  typedef struct packed {
    logic [FIELD_W-1:0] price;
    logic [FIELD_W-1:0] amount;
  } entry_t;

  typedef struct packed {
    logic               pop;
    logic               dec;
    logic               ins;
    logic [FIELD_W-1:0] dec_amt;
    entry_t             ins_entry;
  } book_ctrl_t;

endpackage

[hw/rtl/limit_order_book_matcher_unit.sv]
// Top level: order sequencer, two books and the running backlog modulo 1000000007.
// An accepted order passes through the match, insert and result states before its result is registered.
// The match loop takes one resting entry a cycle; a new order waits until the result state ends.
// The result register lets the next order enter while a result waits to be taken.
// Reset empties both books by clearing their counts and sets the backlog to zero.
module limit_order_book_matcher_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lobm_pkg::FIELD_W-1:0]  price,
  input  logic [lobm_pkg::FIELD_W-1:0]  amount,
  input  logic                          side,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lobm_pkg::FIELD_W-1:0]  backlog_mod,
  output logic                          book_overflow
);
  import lobm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_INSERT, S_RESULT} state_t;

  state_t             state;
  logic [FIELD_W-1:0] ord_price, ord_amount, backlog, backlog_next;
  logic               ord_sell, ovf;
  book_ctrl_t         buy_ctrl, sell_ctrl, other_ctrl, own_ctrl;
  entry_t             buy_top, sell_top, other_top;
  logic [CNT_W-1:0]   buy_count, sell_count, other_count, own_count;
  logic               crosses, take_all, mod_sub, mod_add;
  logic [FIELD_W-1:0] delta;
  logic [FIELD_W:0]   delta_red, mod_diff, mod_sum;

  lobm_book u_buy (.clk(clk), .rst(rst), .high_first(1'b1), .ctrl(buy_ctrl),
                   .top(buy_top), .count(buy_count));
  lobm_book u_sell (.clk(clk), .rst(rst), .high_first(1'b0), .ctrl(sell_ctrl),
                    .top(sell_top), .count(sell_count));

  assign other_top   = ord_sell ? buy_top : sell_top;
  assign other_count = ord_sell ? buy_count : sell_count;
  assign own_count   = ord_sell ? sell_count : buy_count;
  assign crosses     = ord_sell ? (other_top.price >= ord_price)
                                : (other_top.price <= ord_price);
  assign take_all    = ord_amount >= other_top.amount;

  always_comb begin
    other_ctrl = '0;
    own_ctrl   = '0;
    mod_sub    = 1'b0;
    mod_add    = 1'b0;
    delta      = ord_amount;
    own_ctrl.ins_entry = '{price: ord_price, amount: ord_amount};
    other_ctrl.ins_entry = own_ctrl.ins_entry;
    if (state == S_MATCH && ord_amount != '0 && other_count != '0 && crosses) begin
      mod_sub = 1'b1;
      if (take_all) begin
        other_ctrl.pop = 1'b1;
        delta = other_top.amount;
      end else begin
        other_ctrl.dec = 1'b1;
        other_ctrl.dec_amt = ord_amount;
      end
    end
    if (state == S_INSERT && ord_amount != '0 && own_count < CNT_W'(BOOK_DEPTH)) begin
      own_ctrl.ins = 1'b1;
      mod_add = 1'b1;
    end
    buy_ctrl  = ord_sell ? other_ctrl : own_ctrl;
    sell_ctrl = ord_sell ? own_ctrl : other_ctrl;
  end

  // Amounts can reach just above the modulus, so one conditional subtract reduces them.
  assign delta_red = ({1'b0, delta} >= {1'b0, MODULUS}) ? ({1'b0, delta} - {1'b0, MODULUS})
                                                         : {1'b0, delta};
  assign mod_diff  = {1'b0, backlog} - delta_red;
  assign mod_sum   = {1'b0, backlog} + delta_red;

  always_comb begin
    backlog_next = backlog;
    if (mod_sub) begin
      backlog_next = mod_diff[FIELD_W] ? FIELD_W'(mod_diff + {1'b0, MODULUS})
                                       : mod_diff[FIELD_W-1:0];
    end else if (mod_add) begin
      backlog_next = (mod_sum >= {1'b0, MODULUS}) ? FIELD_W'(mod_sum - {1'b0, MODULUS})
                                                   : mod_sum[FIELD_W-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      backlog   <= '0;
      out_valid <= 1'b0;
    end else begin
      backlog <= backlog_next;
      // A waiting word stays until taken; the result state only loads a free register.
      out_valid <= (state == S_RESULT) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ord_price  <= price;
            ord_amount <= amount;
            ord_sell   <= side;
            state      <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (mod_sub) begin
            ord_amount <= take_all ? ord_amount - other_top.amount : '0;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          ovf   <= (ord_amount != '0) && !mod_add;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            backlog_mod   <= backlog;
            book_overflow <= ovf;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_buy_count: assert property (@(posedge clk) disable iff (rst)
    buy_count <= CNT_W'(BOOK_DEPTH)) else $error("buy book count beyond depth");
  a_sell_count: assert property (@(posedge clk) disable iff (rst)
    sell_count <= CNT_W'(BOOK_DEPTH)) else $error("sell book count beyond depth");
  a_backlog_range: assert property (@(posedge clk) disable iff (rst)
    backlog < MODULUS) else $error("backlog not reduced");
  a_one_book: assert property (@(posedge clk) disable iff (rst)
    !(buy_ctrl.ins && sell_ctrl.ins) && !(buy_ctrl.pop && sell_ctrl.pop))
    else $error("both books updated together");

endmodule

[hw/rtl/lobm_cell.sv]
// One book slot: holds an entry and shifts it to or from its neighbours.
module lobm_cell (
  input  logic              clk,
  input  logic              valid,
  input  logic              high_first,
  input  logic              prev_keep,
  input  lobm_pkg::entry_t  prev_entry,
  input  lobm_pkg::entry_t  next_entry,
  input  lobm_pkg::book_ctrl_t ctrl,
  input  logic              is_top,
  output lobm_pkg::entry_t  entry,
  output logic              keep
);
  import lobm_pkg::*;

  // An entry stays put on insertion when it ranks ahead of or level with the new one.
  assign keep = valid && (high_first ? (entry.price >= ctrl.ins_entry.price)
                                     : (entry.price <= ctrl.ins_entry.price));

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      entry <= next_entry;
    end else if (ctrl.ins && !keep) begin
      entry <= prev_keep ? ctrl.ins_entry : prev_entry;
    end else if (ctrl.dec && is_top) begin
      entry.amount <= entry.amount - ctrl.dec_amt;
    end
  end

endmodule

[hw/rtl/lobm_book.sv]
// One sorted price book built as a row of cells, best entry in cell 0.
module lobm_book (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        high_first,
  input  lobm_pkg::book_ctrl_t        ctrl,
  output lobm_pkg::entry_t            top,
  output logic [lobm_pkg::CNT_W-1:0]  count
);
  import lobm_pkg::*;

  entry_t entries [BOOK_DEPTH];
  logic   keeps   [BOOK_DEPTH];

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;
    if (i == 0) begin : g_first
      assign prev_e = ctrl.ins_entry;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = entries[i-1];
      assign prev_k = keeps[i-1];
    end
    if (i == BOOK_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entries[i+1];
    end
    lobm_cell u_cell (
      .clk        (clk),
      .valid      (count > CNT_W'(i)),
      .high_first (high_first),
      .prev_keep  (prev_k),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .ctrl       (ctrl),
      .is_top     (i == 0),
      .entry      (entries[i]),
      .keep       (keeps[i])
    );
  end

  assign top = entries[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.pop) begin
      count <= count - 1'b1;
    end else if (ctrl.ins) begin
      count <= count + 1'b1;
    end
  end

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the limit order book matcher: directed and random order flow against a book model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int N_RANDOM        = 1330;
  localparam int MAX_ENTRIES     = 2100;

  typedef enum logic {SIDE_BUY = 1'b0, SIDE_SELL = 1'b1} side_e;

  typedef struct {
    logic [FIELD_W-1:0] backlog;
    logic               overflow;
  } book_result_t;

  // Order book model; books hold the best price last, unlike the block, which keeps it in cell 0.
  class book_scoreboard;
    entry_t       bids[$];
    entry_t       asks[$];
    longint       total;
    book_result_t pending[$];
    int           errors;

    function void note_order(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] amt, side_e sd);
      longint       left;
      entry_t       e;
      int           pos;
      book_result_t r;
      left = amt;
      r.overflow = 1'b0;
      if (sd == SIDE_SELL) begin
        while (left > 0 && bids.size() > 0 && bids[$].price >= px) begin
          if (left >= bids[$].amount) begin
            left -= bids[$].amount; total -= bids[$].amount; void'(bids.pop_back());
          end else begin
            bids[$].amount = bids[$].amount - left; total -= left; left = 0;
          end
        end
      end else begin
        while (left > 0 && asks.size() > 0 && asks[$].price <= px) begin
          if (left >= asks[$].amount) begin
            left -= asks[$].amount; total -= asks[$].amount; void'(asks.pop_back());
          end else begin
            asks[$].amount = asks[$].amount - left; total -= left; left = 0;
          end
        end
      end
      if (left > 0) begin
        e.price = px;
        e.amount = left[FIELD_W-1:0];
        if (sd == SIDE_SELL) begin
          if (asks.size() >= BOOK_DEPTH) r.overflow = 1'b1;
          else begin
            pos = 0;
            while (pos < asks.size() && asks[pos].price > px) pos++;
            asks.insert(pos, e); total += left;
          end
        end else begin
          if (bids.size() >= BOOK_DEPTH) r.overflow = 1'b1;
          else begin
            pos = 0;
            while (pos < bids.size() && bids[pos].price < px) pos++;
            bids.insert(pos, e); total += left;
          end
        end
      end
      r.backlog = FIELD_W'(total % 64'd1000000007);
      pending.push_back(r);
    endfunction

    task check_result(logic [FIELD_W-1:0] bk, logic ov);
      book_result_t want;
      if (pending.size() == 0) begin
        report("result with no order outstanding"); return;
      end
      want = pending.pop_front();
      if (bk !== want.backlog) report($sformatf("backlog_mod %0d, want %0d", bk, want.backlog));
      if (ov !== want.overflow)
        report($sformatf("book_overflow %0b, want %0b", ov, want.overflow));
    endtask

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [FIELD_W-1:0] price = '0, amount = '0;
  logic side = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic [FIELD_W-1:0] backlog_mod;
  logic book_overflow;

  book_scoreboard sb = new();
  int  idle_cycles;
  bit  stim_done;
  bit  hold_off;
  bit  filling;

  limit_order_book_matcher_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both sides are sampled at the rising edge; the model sees each accepted word.
  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else begin
      if (in_valid && !in_stall) sb.note_order(price, amount, side_e'(side));
      if (out_valid && !out_stall) sb.check_result(backlog_mod, book_overflow);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("limit_order_book_matcher_unit regression: fail");
      $finish;
    end
  end

  // Receiver stalls on its own pattern, with one long hold-off early on.
  initial begin
    int n;
    @(negedge clk);
    while (!stim_done || sb.pending.size() > 0) begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (n = 0; n < 300; n++) @(negedge clk);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_stall <= ($urandom_range(0, 1) == 0);
        1: out_stall <= 1'b0;
        default: out_stall <= ($urandom_range(0, 9) < 2);
      endcase
    end
    out_stall <= 1'b0;
  end

  task automatic send_order(input logic [FIELD_W-1:0] px, input logic [FIELD_W-1:0] amt,
                            input side_e sd);
    in_valid <= 1'b1;
    price    <= px;
    amount   <= amt;
    side     <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_gap();
    int g;
    if (filling || $urandom_range(0, 7) != 0) return;
    in_valid <= 1'b0;
    g = $urandom_range(1, 6);
    repeat (g) @(negedge clk);
  endtask

  // Prices cluster in a narrow band so orders cross often; a few span the full field.
  function automatic logic [FIELD_W-1:0] pick_price();
    case ($urandom_range(0, 9))
      0: return FIELD_W'($urandom_range(0, 1000000000));
      1: return FIELD_W'($urandom) ;
      default: return FIELD_W'($urandom_range(500, 540));
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return FIELD_W'($urandom);
      1: return '0;
      2: return FIELD_W'($urandom_range(999999000, 1000000000));
      default: return FIELD_W'($urandom_range(1, 200));
    endcase
  endfunction

  initial begin
    int i, burst;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, equal-price priority, zero amount and price, partial fills.
    send_order(30'd100, 30'd5, SIDE_BUY);
    send_order(30'd100, 30'd7, SIDE_BUY);
    send_order(30'd90, 30'd6, SIDE_SELL);
    send_order(30'd100, 30'd3, SIDE_SELL);
    send_order(30'd0, 30'd0, SIDE_BUY);
    send_order(30'd0, 30'd9, SIDE_BUY);
    send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_SELL);
    send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_SELL);
    send_order(30'd1000000000, 30'd1000000000, SIDE_SELL);
    send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY);
    send_order(30'd1, 30'd1, SIDE_SELL);
    send_order(30'd1, 30'h3FFFFFFF, SIDE_BUY);
    send_order(30'd1, 30'd2, SIDE_SELL);
    send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL);

    // Long hold-off on the receiver while words keep arriving.
    hold_off = 1'b1;
    filling = 1'b1;
    for (i = 0; i < 20; i++) send_order(pick_price(), pick_amount(), side_e'($urandom_range(0, 1)));
    filling = 1'b0;

    // Fill the sell book past its depth to reach the overflow case, then drain it.
    for (i = 0; i < BOOK_DEPTH + 8; i++) begin
      send_order(FIELD_W'(2000000 + (i % 50)), FIELD_W'($urandom_range(1, 9)), SIDE_SELL);
      random_gap();
    end
    send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY);

    i = 0;
    while (i < N_RANDOM - BOOK_DEPTH - 8) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_order(pick_price(), pick_amount(), side_e'($urandom_range(0, 1)));
        i++;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("limit_order_book_matcher_unit regression: pass");
    else
      $display("limit_order_book_matcher_unit regression: fail");
    $finish;
  end
endmodule

[files.f]
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_cell.sv
hw/rtl/lobm_book.sv
hw/rtl/limit_order_book_matcher_unit.sv
tb/sv/tb.sv
